@@ rtl/core/crcz_pkg.sv @@
// Shared constants, register indexes and sequencer states for the CRC zero-shift operator.
package crcz_pkg;

    localparam int CRC_WIDTH_DEF = 32;

    // CRC-32C reflected; the normal form of this polynomial is 0x1EDC6F41.
    localparam logic [31:0] POLY_RESET = 32'h82F6_3B78;

    localparam int SHIFT_W = 5;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd13;

    // The one-bit operator is squared three times to reach one byte.
    localparam int BASE_SQUARES = 3;
    localparam int SQ_CNT_W = 6;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRC_POLY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHIFT_LOG2 = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SQ_LOAD,
        ST_SQ_LOADW,
        ST_SQ_ACC,
        ST_AP_ADDR,
        ST_AP_ACC
    } state_t;

endpackage

@@ rtl/core/crcz_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module crcz_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/core/crc_zero_shift_operator.sv @@
// Top level: advances a reflected CRC register over 2^shift_log2 zero bytes.
//
// An item is taken when start is high and busy is low; its result appears on value_out
// for exactly one cycle with done high, and the receiver cannot stall it. All work runs
// through one AND-XOR accumulator that folds in one operator row per cycle while in an
// accumulate state, read from a pair of ping-pong row memories. Applying a cached operator
// runs ST_AP_ADDR and then ST_AP_ACC over every row, and busy falls in the done cycle. The
// first item after reset or after a write to CRC_POLY or SHIFT_LOG2 first rebuilds the
// operator: ST_INIT writes the one-zero-bit operator, which is then squared 3 + shift_log2
// times. Register writes are taken only while busy is low.
module crc_zero_shift_operator #(
    parameter int CRC_WIDTH = crcz_pkg::CRC_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [CRC_WIDTH-1:0]             value_in,
    output logic                             done,
    output logic [CRC_WIDTH-1:0]             value_out,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [crcz_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [CRC_WIDTH-1:0]             cfg_data
);

    localparam int IDX_W = $clog2(CRC_WIDTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CRC_WIDTH - 1);

    crcz_pkg::state_t state_reg, state_next;

    logic [CRC_WIDTH-1:0]          poly_reg, poly_next;
    logic [crcz_pkg::SHIFT_W-1:0]  shift_reg, shift_next;
    logic                          ready_reg, ready_next;
    logic                          bank_reg, bank_next;
    logic [IDX_W-1:0]              row_reg, row_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic [crcz_pkg::SQ_CNT_W-1:0] sq_cnt_reg, sq_cnt_next;
    logic                          done_reg, done_next;

    logic [CRC_WIDTH-1:0] acc_reg, acc_next;
    logic [CRC_WIDTH-1:0] mul_vec_reg, mul_vec_next;
    logic [CRC_WIDTH-1:0] in_vec_reg, in_vec_next;
    logic [CRC_WIDTH-1:0] value_out_reg, value_out_next;

    logic                          cfg_we;
    logic                          in_take;
    logic [IDX_W-1:0]              rd_addr;
    logic                          wr_en;
    logic                          wr_bank;
    logic [IDX_W-1:0]              wr_addr;
    logic [CRC_WIDTH-1:0]          wr_data;
    logic [CRC_WIDTH-1:0]          rd_data0;
    logic [CRC_WIDTH-1:0]          rd_data1;
    logic [CRC_WIDTH-1:0]          rd_src;
    logic [CRC_WIDTH-1:0]          acc_sum;
    logic [crcz_pkg::SQ_CNT_W-1:0] sq_total;
    logic [crcz_pkg::SQ_CNT_W-1:0] sq_cnt_inc;

    assign busy      = (state_reg != crcz_pkg::ST_IDLE);
    assign cfg_ready = !busy;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign in_take   = start && !busy;
    assign done      = done_reg;
    assign value_out = value_out_reg;

    // Bank bank_reg holds the current operator; the other bank receives the square.
    assign rd_src     = bank_reg ? rd_data1 : rd_data0;
    assign acc_sum    = acc_reg ^ (mul_vec_reg[idx_reg] ? rd_src : '0);
    assign sq_total   = crcz_pkg::SQ_CNT_W'(crcz_pkg::BASE_SQUARES)
                      + crcz_pkg::SQ_CNT_W'(shift_reg);
    assign sq_cnt_inc = sq_cnt_reg + crcz_pkg::SQ_CNT_W'(1);

    crcz_ram #(
        .WIDTH (CRC_WIDTH),
        .DEPTH (CRC_WIDTH)
    ) u_bank0 (
        .clk     (clk),
        .wr_en   (wr_en && !wr_bank),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data0)
    );

    crcz_ram #(
        .WIDTH (CRC_WIDTH),
        .DEPTH (CRC_WIDTH)
    ) u_bank1 (
        .clk     (clk),
        .wr_en   (wr_en && wr_bank),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data1)
    );

    always_comb
    begin
        state_next     = state_reg;
        poly_next      = poly_reg;
        shift_next     = shift_reg;
        ready_next     = ready_reg;
        bank_next      = bank_reg;
        row_next       = row_reg;
        idx_next       = idx_reg;
        sq_cnt_next    = sq_cnt_reg;
        done_next      = 1'b0;
        acc_next       = acc_reg;
        mul_vec_next   = mul_vec_reg;
        in_vec_next    = in_vec_reg;
        value_out_next = value_out_reg;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_bank        = !bank_reg;
        wr_addr        = row_reg;
        wr_data        = acc_sum;

        if (cfg_we)
        begin
            case (cfg_index)
                crcz_pkg::CFG_CRC_POLY:
                begin
                    poly_next  = cfg_data;
                    ready_next = 1'b0;
                end
                crcz_pkg::CFG_SHIFT_LOG2:
                begin
                    shift_next = cfg_data[crcz_pkg::SHIFT_W-1:0];
                    ready_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            crcz_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    in_vec_next = value_in;
                    row_next    = '0;
                    // A register write in the same cycle invalidates the operator first.
                    if (ready_reg && !cfg_we)
                    begin
                        state_next = crcz_pkg::ST_AP_ADDR;
                    end
                    else
                    begin
                        state_next = crcz_pkg::ST_INIT;
                    end
                end
            end
            crcz_pkg::ST_INIT:
            begin
                // One-zero-bit operator: row 0 is the polynomial, row n is bit n-1.
                wr_en   = 1'b1;
                wr_bank = 1'b0;
                wr_data = (row_reg == '0) ? poly_reg
                        : (CRC_WIDTH'(1) << (row_reg - IDX_W'(1)));
                if (row_reg == LAST_IDX)
                begin
                    row_next    = '0;
                    bank_next   = 1'b0;
                    sq_cnt_next = '0;
                    state_next  = crcz_pkg::ST_SQ_LOAD;
                end
                else
                begin
                    row_next = row_reg + IDX_W'(1);
                end
            end
            crcz_pkg::ST_SQ_LOAD:
            begin
                rd_addr    = row_reg;
                state_next = crcz_pkg::ST_SQ_LOADW;
            end
            crcz_pkg::ST_SQ_LOADW:
            begin
                mul_vec_next = rd_src;
                acc_next     = '0;
                idx_next     = '0;
                state_next   = crcz_pkg::ST_SQ_ACC;
            end
            crcz_pkg::ST_SQ_ACC:
            begin
                acc_next = acc_sum;
                if (idx_reg == LAST_IDX)
                begin
                    wr_en = 1'b1;
                    if (row_reg == LAST_IDX)
                    begin
                        row_next    = '0;
                        bank_next   = !bank_reg;
                        sq_cnt_next = sq_cnt_inc;
                        if (sq_cnt_inc == sq_total)
                        begin
                            ready_next = 1'b1;
                            state_next = crcz_pkg::ST_AP_ADDR;
                        end
                        else
                        begin
                            state_next = crcz_pkg::ST_SQ_LOAD;
                        end
                    end
                    else
                    begin
                        row_next   = row_reg + IDX_W'(1);
                        state_next = crcz_pkg::ST_SQ_LOAD;
                    end
                end
                else
                begin
                    rd_addr  = idx_reg + IDX_W'(1);
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            crcz_pkg::ST_AP_ADDR:
            begin
                mul_vec_next = in_vec_reg;
                acc_next     = '0;
                idx_next     = '0;
                state_next   = crcz_pkg::ST_AP_ACC;
            end
            crcz_pkg::ST_AP_ACC:
            begin
                acc_next = acc_sum;
                if (idx_reg == LAST_IDX)
                begin
                    value_out_next = acc_sum;
                    done_next      = 1'b1;
                    state_next     = crcz_pkg::ST_IDLE;
                end
                else
                begin
                    rd_addr  = idx_reg + IDX_W'(1);
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = crcz_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= crcz_pkg::ST_IDLE;
            poly_reg   <= CRC_WIDTH'(crcz_pkg::POLY_RESET);
            shift_reg  <= crcz_pkg::SHIFT_RESET;
            ready_reg  <= 1'b0;
            bank_reg   <= 1'b0;
            row_reg    <= '0;
            idx_reg    <= '0;
            sq_cnt_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            poly_reg   <= poly_next;
            shift_reg  <= shift_next;
            ready_reg  <= ready_next;
            bank_reg   <= bank_next;
            row_reg    <= row_next;
            idx_reg    <= idx_next;
            sq_cnt_reg <= sq_cnt_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        mul_vec_reg   <= mul_vec_next;
        in_vec_reg    <= in_vec_next;
        value_out_reg <= value_out_next;
    end

    // An accepted word always makes the block busy on the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> busy)
        else $error("accepted word did not raise busy");

    // A result is only produced from a fully built operator.
    a_done_ready: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ready_reg)
        else $error("result strobe without a built operator");

    // A write to CRC_POLY or SHIFT_LOG2 invalidates the cached operator.
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && (cfg_index == crcz_pkg::CFG_CRC_POLY
                    || cfg_index == crcz_pkg::CFG_SHIFT_LOG2)) |=> !ready_reg)
        else $error("register write left the operator marked valid");

    // The result strobe is never high in back-to-back cycles.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

endmodule
